>>> hdl/plb_pkg.sv
// ----------------------------------------------------------------------------
// plb_pkg
// Shared constants, codes and controller/datapath bundles of the positional
// list buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package plb_pkg;

  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 10;
  localparam int POS2_W     = 9;
  localparam int RPOS_W     = POS_W + 1;
  localparam int IN_W       = 56;
  localparam int OUT_W      = 48;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SWAP   = 2'd2,
    OP_READ   = 2'd3
  } plb_op_e;

  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_BAD_POS = 2'd1,
    RES_FULL    = 2'd2
  } plb_res_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } plb_cnt_op_e;

  typedef struct packed {
    logic        load;
    logic        mv_init;
    logic        mv_step;
    logic        mv_drain;
    logic        wr_elem;
    logic        rd_p1;
    logic        rd_p2;
    logic        cap_tmp;
    logic        cap_rd;
    logic        wr_p1;
    logic        wr_p2;
    logic        finish;
    plb_res_e    res;
    plb_cnt_op_e cnt_op;
  } plb_cmd_t;

  typedef struct packed {
    plb_op_e op;
    logic    p1_ok;
    logic    p2_ok;
    logic    ins_ok;
    logic    full;
    logic    same;
    logic    ins_tail;
    logic    del_tail;
    logic    at_end;
    logic    out_busy;
  } plb_stat_t;

endpackage

`default_nettype wire

>>> hdl/plb_ram.sv
// ----------------------------------------------------------------------------
// plb_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module plb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/plb_ctrl.sv
// ----------------------------------------------------------------------------
// plb_ctrl
// Command sequencer: checks positions, steps shifts and swaps through the
// entry memory and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module plb_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire plb_pkg::plb_stat_t stat_i,
  output      plb_pkg::plb_cmd_t  cmd_o
);

  import plb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MOVE,
    S_DRAIN,
    S_PUT,
    S_RD_CAP,
    S_SW_B,
    S_SW_C,
    S_SW_D,
    S_FINISH
  } state_e;

  state_e      state_q, state_d;
  plb_res_e    res_q, res_d;
  plb_cnt_op_e cnt_op_q, cnt_op_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    res_d        = res_q;
    cnt_op_d     = cnt_op_q;
    cmd_o        = '0;
    cmd_o.res    = res_q;
    cmd_o.cnt_op = cnt_op_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        res_d    = RES_OK;
        cnt_op_d = CNT_HOLD;
        case (stat_i.op)
          OP_INSERT: begin
            if (!stat_i.ins_ok) begin
              res_d   = RES_BAD_POS;
              state_d = S_FINISH;
            end else if (stat_i.full) begin
              res_d   = RES_FULL;
              state_d = S_FINISH;
            end else if (stat_i.ins_tail) begin
              cnt_op_d = CNT_INC;
              state_d  = S_PUT;
            end else begin
              cnt_op_d      = CNT_INC;
              cmd_o.mv_init = 1'b1;
              state_d       = S_MOVE;
            end
          end
          OP_DELETE: begin
            if (!stat_i.p1_ok) begin
              res_d   = RES_BAD_POS;
              state_d = S_FINISH;
            end else if (stat_i.del_tail) begin
              cnt_op_d = CNT_DEC;
              state_d  = S_FINISH;
            end else begin
              cnt_op_d      = CNT_DEC;
              cmd_o.mv_init = 1'b1;
              state_d       = S_MOVE;
            end
          end
          OP_SWAP: begin
            if (!stat_i.p1_ok || !stat_i.p2_ok) begin
              res_d   = RES_BAD_POS;
              state_d = S_FINISH;
            end else if (stat_i.same) begin
              state_d = S_FINISH;
            end else begin
              cmd_o.rd_p1 = 1'b1;
              state_d     = S_SW_B;
            end
          end
          default: begin
            if (!stat_i.p1_ok) begin
              res_d   = RES_BAD_POS;
              state_d = S_FINISH;
            end else begin
              cmd_o.rd_p1 = 1'b1;
              state_d     = S_RD_CAP;
            end
          end
        endcase
      end
      S_MOVE: begin
        cmd_o.mv_step = 1'b1;
        if (stat_i.at_end) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd_o.mv_drain = 1'b1;
        state_d        = (stat_i.op == OP_INSERT) ? S_PUT : S_FINISH;
      end
      S_PUT: begin
        cmd_o.wr_elem = 1'b1;
        state_d       = S_FINISH;
      end
      S_RD_CAP: begin
        cmd_o.cap_rd = 1'b1;
        state_d      = S_FINISH;
      end
      S_SW_B: begin
        cmd_o.cap_tmp = 1'b1;
        cmd_o.rd_p2   = 1'b1;
        state_d       = S_SW_C;
      end
      S_SW_C: begin
        cmd_o.wr_p1 = 1'b1;
        state_d     = S_SW_D;
      end
      S_SW_D: begin
        cmd_o.wr_p2 = 1'b1;
        state_d     = S_FINISH;
      end
      S_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      res_q    <= RES_OK;
      cnt_op_q <= CNT_HOLD;
    end else begin
      state_q  <= state_d;
      res_q    <= res_d;
      cnt_op_q <= cnt_op_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/plb_dp.sv
// ----------------------------------------------------------------------------
// plb_dp
// Datapath: position resolution and checks, entry memory with its shift
// pointers, swap holding register, count and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module plb_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire plb_pkg::plb_op_e                in_op_i,
  input  wire logic [plb_pkg::POS_W-1:0]       in_pos_i,
  input  wire logic [plb_pkg::POS2_W-1:0]      in_pos2_i,
  input  wire logic [plb_pkg::DATA_WIDTH-1:0]  in_elem_i,
  input  wire plb_pkg::plb_cmd_t               cmd_i,
  output      plb_pkg::plb_stat_t              stat_o,
  input  wire logic                            out_ready_i,
  output      logic                            out_valid_o,
  output      plb_pkg::plb_res_e               out_res_o,
  output      logic [plb_pkg::CNT_W-1:0]       out_count_o,
  output      logic [plb_pkg::DATA_WIDTH-1:0]  out_rdata_o
);

  import plb_pkg::*;

  plb_op_e                  op_q;
  logic signed [RPOS_W-1:0] r1_q, r2_q, r1_d, r2_d;
  logic signed [RPOS_W-1:0] pos_x, pos2_x, cnt_x;
  logic [DATA_WIDTH-1:0]    elem_q, tmp_q, rd_q;
  logic [CNT_W-1:0]         count_q, count_d, count_m1;
  logic [ADDR_W-1:0]        src_q, end_q, dst_q;
  logic                     wpend_q;
  logic                     out_valid_q;
  plb_res_e                 out_res_q;
  logic [CNT_W-1:0]         out_count_q;
  logic [DATA_WIDTH-1:0]    out_rdata_q;

  logic                     ram_we, ram_re;
  logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0]    ram_wdata, ram_rdata;

  assign pos_x  = {in_pos_i[POS_W-1], in_pos_i};
  assign pos2_x = {{(RPOS_W-POS2_W){in_pos2_i[POS2_W-1]}}, in_pos2_i};
  assign cnt_x  = {{(RPOS_W-CNT_W){1'b0}}, count_q};
  assign r1_d   = pos_x[RPOS_W-1] ? pos_x + cnt_x : pos_x;
  assign r2_d   = pos2_x[RPOS_W-1] ? pos2_x + cnt_x : pos2_x;

  assign count_m1 = count_q - CNT_W'(1);

  always_comb begin
    stat_o.op       = op_q;
    stat_o.p1_ok    = !r1_q[RPOS_W-1] && (r1_q < cnt_x);
    stat_o.p2_ok    = !r2_q[RPOS_W-1] && (r2_q < cnt_x);
    stat_o.ins_ok   = !r1_q[RPOS_W-1] && (r1_q <= cnt_x);
    stat_o.full     = (count_q == CNT_W'(CAPACITY));
    stat_o.same     = (r1_q == r2_q);
    stat_o.ins_tail = (r1_q == cnt_x);
    stat_o.del_tail = (r1_q == cnt_x - RPOS_W'(1));
    stat_o.at_end   = (src_q == end_q);
    stat_o.out_busy = out_valid_q && !out_ready_i;
  end

  always_comb begin
    case (cmd_i.cnt_op)
      CNT_INC: count_d = count_q + CNT_W'(1);
      CNT_DEC: count_d = count_m1;
      default: count_d = count_q;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dst_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = src_q;
    if (cmd_i.mv_step) begin
      ram_re = 1'b1;
      ram_we = wpend_q;
    end
    if (cmd_i.mv_drain) begin
      ram_we = 1'b1;
    end
    if (cmd_i.rd_p1) begin
      ram_re    = 1'b1;
      ram_raddr = r1_q[ADDR_W-1:0];
    end
    if (cmd_i.rd_p2) begin
      ram_re    = 1'b1;
      ram_raddr = r2_q[ADDR_W-1:0];
    end
    if (cmd_i.wr_elem) begin
      ram_we    = 1'b1;
      ram_waddr = r1_q[ADDR_W-1:0];
      ram_wdata = elem_q;
    end
    if (cmd_i.wr_p1) begin
      ram_we    = 1'b1;
      ram_waddr = r1_q[ADDR_W-1:0];
    end
    if (cmd_i.wr_p2) begin
      ram_we    = 1'b1;
      ram_waddr = r2_q[ADDR_W-1:0];
      ram_wdata = tmp_q;
    end
  end

  plb_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      wpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.mv_init || cmd_i.mv_drain) begin
        wpend_q <= 1'b0;
      end else if (cmd_i.mv_step) begin
        wpend_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_op_i;
      r1_q   <= r1_d;
      r2_q   <= r2_d;
      elem_q <= in_elem_i;
      rd_q   <= '0;
    end
    if (cmd_i.mv_init) begin
      if (op_q == OP_INSERT) begin
        src_q <= count_m1[ADDR_W-1:0];
        end_q <= r1_q[ADDR_W-1:0];
      end else begin
        src_q <= r1_q[ADDR_W-1:0] + ADDR_W'(1);
        end_q <= count_m1[ADDR_W-1:0];
      end
    end else if (cmd_i.mv_step) begin
      if (op_q == OP_INSERT) begin
        src_q <= src_q - ADDR_W'(1);
        dst_q <= src_q + ADDR_W'(1);
      end else begin
        src_q <= src_q + ADDR_W'(1);
        dst_q <= src_q - ADDR_W'(1);
      end
    end
    if (cmd_i.cap_tmp) begin
      tmp_q <= ram_rdata;
    end
    if (cmd_i.cap_rd) begin
      rd_q <= ram_rdata;
    end
    if (cmd_i.finish) begin
      out_res_q   <= cmd_i.res;
      out_count_q <= count_d;
      out_rdata_q <= rd_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign out_count_o = out_count_q;
  assign out_rdata_o = out_rdata_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && (cmd_i.cnt_op == CNT_INC) |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not advance the count");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.finish))
    else $error("result raised without a finished command");

  a_full_no_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && stat_o.full |-> cmd_i.cnt_op != CNT_INC)
    else $error("count advanced on a full list");
`endif

endmodule

`default_nettype wire

>>> hdl/positional_list_buffer.sv
// ----------------------------------------------------------------------------
// positional_list_buffer
// Ordered list store: insert, delete, swap and read at a position, with
// negative positions counted back from the current count.
// ----------------------------------------------------------------------------
//   channel   dir   fields (low bit first)
//   s_axis    in    command[1:0] position[11:2] second_position[20:12]
//                   element[52:21]
//   m_axis    out   status[1:0] count[10:2] read_data[42:11]
//
// One command at a time; a new transfer is taken only once the last command
// has finished. Inserts and deletes not at the tail move each entry after the
// position, one at a time, through the one read port of the entry memory.
// Entries are not cleared at reset; only the count and control reset.
// A waiting result is held in the output register while the next command
// is taken in; a command finishes only once that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_buffer (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid_i,
  output      logic                     s_axis_tready_o,
  // command, position, second_position, element
  input  wire logic [plb_pkg::IN_W-1:0] s_axis_tdata_i,
  output      logic                     m_axis_tvalid_o,
  input  wire logic                     m_axis_tready_i,
  // status, count, read_data
  output      logic [plb_pkg::OUT_W-1:0] m_axis_tdata_o
);

  import plb_pkg::*;

  plb_cmd_t              cmd;
  plb_stat_t             stat;
  plb_res_e              out_res;
  logic [CNT_W-1:0]      out_count;
  logic [DATA_WIDTH-1:0] out_rdata;

  plb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  plb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_op_i     (plb_op_e'(s_axis_tdata_i[1:0])),
    .in_pos_i    (s_axis_tdata_i[11:2]),
    .in_pos2_i   (s_axis_tdata_i[20:12]),
    .in_elem_i   (s_axis_tdata_i[52:21]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_res_o   (out_res),
    .out_count_o (out_count),
    .out_rdata_o (out_rdata)
  );

  assign m_axis_tdata_o = {5'b0, out_rdata, out_count, out_res};

endmodule

`default_nettype wire
